// File: hw/rtl/ppr_pkg.sv
// shared constants, types and state codes of the pulse peak heart-rate block
package ppr_pkg;

    // sample window geometry
    localparam int WINDOW_LEN  = 7;
    localparam int MID_SLOT    = 3;
    localparam int FILL_W      = 3;

    // field widths
    localparam int SAMPLE_W    = 16;
    localparam int TIME_W      = 32;
    localparam int RATE_W      = 8;
    localparam int REFR_W      = 16;

    // rate arithmetic
    localparam logic [15:0] RATE_NUM         = 16'd60000;
    localparam logic [7:0]  RATE_MAX         = 8'd255;
    localparam logic [15:0] REFRACTORY_RESET = 16'd425;

    // rate divider: 16-bit dividend over 32-bit divisor, one bit a cycle
    localparam int DIVIDEND_W  = 16;
    localparam int DIV_STEPS   = 16;
    localparam int DIV_CNT_W   = 4;

    // defaults for top level parameters
    localparam int AVG_COUNT_DEF   = 7;
    localparam int QUEUE_DEPTH_DEF = 4;

    // command passed from the front part to the back part
    typedef struct packed {
        logic              peak;
        logic [TIME_W-1:0] interval;
    } ppr_cmd_t;

    // back part sequencer states
    typedef enum logic [2:0] {
        B_IDLE,
        B_DIV_RATE,
        B_PUSH,
        B_SUM,
        B_DIV_AVG,
        B_OUT
    } ppr_back_state_t;

endpackage

// File: hw/rtl/ppr_div.sv
// iterative restoring divider, one quotient bit per cycle
module ppr_div
    import ppr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [TIME_W-1:0]     divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [TIME_W-1:0]     rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [TIME_W-1:0]     dsr_reg, dsr_next;
    logic [TIME_W:0]       shifted;
    logic [TIME_W:0]       diff;
    logic                  ge;

    // one restoring step
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff    = shifted - {1'b0, dsr_reg};
        ge      = (shifted >= {1'b0, dsr_reg});
    end

    // sequencing of the steps
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_STEPS - 1);
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: hw/rtl/ppr_queue.sv
// short command queue between the front and back parts
module ppr_queue
    import ppr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  ppr_cmd_t push_data,
    input  logic     pop,
    output ppr_cmd_t head,
    output logic     full,
    output logic     empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    ppr_cmd_t          entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hw/rtl/ppr_front.sv
// front part: sample window, peak test and refractory check
module ppr_front
    import ppr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [REFR_W-1:0]   cfg_wr_data,
    input  logic                in_valid,
    input  logic                queue_full,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [TIME_W-1:0]   timestamp_ms,
    output logic                in_ready,
    output logic                cmd_push,
    output ppr_cmd_t            cmd
);

    logic [REFR_W-1:0]   refr_reg;
    logic [SAMPLE_W-1:0] swin_reg [WINDOW_LEN];
    logic [SAMPLE_W-1:0] swin_next [WINDOW_LEN];
    logic [TIME_W-1:0]   twin_reg [WINDOW_LEN];
    logic [TIME_W-1:0]   twin_next [WINDOW_LEN];
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [TIME_W-1:0]   last_peak_reg, last_peak_next;
    logic                win_full;
    logic                accept;
    logic                is_peak;
    logic [SAMPLE_W-1:0] mid;
    logic [TIME_W-1:0]   since_last;
    logic                counted;

    assign in_ready = !queue_full;
    assign accept   = in_valid && !queue_full;
    assign win_full = (fill_reg == FILL_W'(WINDOW_LEN));

    // window after this item: fill upward, then shift down
    always_comb
    begin
        for (int i = 0; i < WINDOW_LEN - 1; i++)
        begin
            if (win_full)
            begin
                swin_next[i] = swin_reg[i + 1];
                twin_next[i] = twin_reg[i + 1];
            end
            else if (fill_reg == FILL_W'(i))
            begin
                swin_next[i] = sample;
                twin_next[i] = timestamp_ms;
            end
            else
            begin
                swin_next[i] = swin_reg[i];
                twin_next[i] = twin_reg[i];
            end
        end
        if (win_full || fill_reg == FILL_W'(WINDOW_LEN - 1))
        begin
            swin_next[WINDOW_LEN-1] = sample;
            twin_next[WINDOW_LEN-1] = timestamp_ms;
        end
        else
        begin
            swin_next[WINDOW_LEN-1] = swin_reg[WINDOW_LEN-1];
            twin_next[WINDOW_LEN-1] = twin_reg[WINDOW_LEN-1];
        end
        fill_next = win_full ? fill_reg : fill_reg + 1'b1;
    end

    // peak test on the middle slot, refractory check on its time
    always_comb
    begin
        mid     = swin_next[MID_SLOT];
        is_peak = (mid >= swin_next[2]) && (mid >= swin_next[1]) && (mid > swin_next[0])
               && (mid >= swin_next[4]) && (mid >= swin_next[5]) && (mid > swin_next[6]);
        since_last     = twin_next[MID_SLOT] - last_peak_reg;
        counted        = is_peak && (since_last > TIME_W'(refr_reg));
        last_peak_next = counted ? twin_next[MID_SLOT] : last_peak_reg;
        cmd_push       = accept;
        cmd.peak       = counted;
        cmd.interval   = since_last;
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            refr_reg <= REFRACTORY_RESET;
        end
        else if (cfg_wr_en)
        begin
            refr_reg <= cfg_wr_data;
        end
    end

    // window and peak time state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                swin_reg[i] <= '0;
                twin_reg[i] <= '0;
            end
            fill_reg      <= '0;
            last_peak_reg <= '0;
        end
        else if (accept)
        begin
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                swin_reg[i] <= swin_next[i];
                twin_reg[i] <= twin_next[i];
            end
            fill_reg      <= fill_next;
            last_peak_reg <= last_peak_next;
        end
    end

endmodule

// File: hw/rtl/ppr_back.sv
// back part: rate division, rate list, averaging and result register
module ppr_back
    import ppr_pkg::*;
#(
    parameter int AVG_COUNT = AVG_COUNT_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              queue_empty,
    input  ppr_cmd_t          head,
    output logic              cmd_pop,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [RATE_W-1:0] heart_rate,
    output logic              peak_found
);

    localparam int AIDX_W = $clog2(AVG_COUNT);
    localparam int RF_W   = $clog2(AVG_COUNT + 1);
    localparam int SUM_W  = $clog2(AVG_COUNT * 255 + 1);
    localparam logic [AIDX_W-1:0] IDX_LAST = AIDX_W'(AVG_COUNT - 1);

    // mean by reciprocal multiplication, exact over the whole sum range
    localparam int MEAN_SHIFT = SUM_W + AIDX_W;
    localparam int RECIP_W    = MEAN_SHIFT + 1;
    localparam int PROD_W     = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] MEAN_RECIP =
        RECIP_W'(((1 << MEAN_SHIFT) + AVG_COUNT - 1) / AVG_COUNT);

    ppr_back_state_t       state_reg, state_next;
    logic [RATE_W-1:0]     list_reg [AVG_COUNT];
    logic [RATE_W-1:0]     list_next [AVG_COUNT];
    logic [RF_W-1:0]       rfill_reg, rfill_next;
    logic [RATE_W-1:0]     held_reg, held_next;
    logic [AIDX_W-1:0]     idx_reg, idx_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic                  ovalid_reg, ovalid_next;
    logic [RATE_W-1:0]     orate_reg, orate_next;
    logic                  opeak_reg, opeak_next;
    logic                  list_wr;
    logic                  out_free;
    logic                  rlist_full;
    logic [RATE_W-1:0]     rate;
    logic [RATE_W-1:0]     last_after;
    logic [PROD_W-1:0]     mean_prod;
    logic [RATE_W-1:0]     mean;
    logic                  div_start;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [TIME_W-1:0]     div_divisor;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] div_quo;

    // divider for the rate
    ppr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign out_free   = !ovalid_reg || out_ready;
    assign rlist_full = (rfill_reg >= RF_W'(AVG_COUNT));
    assign rate       = (div_quo > DIVIDEND_W'(RATE_MAX)) ? RATE_MAX : div_quo[RATE_W-1:0];
    assign last_after = (rfill_reg >= RF_W'(AVG_COUNT - 1)) ? rate : list_reg[AVG_COUNT-1];

    // truncated mean of the summed list
    assign mean_prod  = PROD_W'(sum_reg) * PROD_W'(MEAN_RECIP);
    assign mean       = mean_prod[MEAN_SHIFT +: RATE_W];

    // rate list after a push: fill upward, then shift out the oldest
    always_comb
    begin
        for (int k = 0; k < AVG_COUNT - 1; k++)
        begin
            if (rlist_full)
            begin
                list_next[k] = list_reg[k + 1];
            end
            else if (rfill_reg[AIDX_W-1:0] == AIDX_W'(k))
            begin
                list_next[k] = rate;
            end
            else
            begin
                list_next[k] = list_reg[k];
            end
        end
        if (rlist_full || rfill_reg == RF_W'(AVG_COUNT - 1))
        begin
            list_next[AVG_COUNT-1] = rate;
        end
        else
        begin
            list_next[AVG_COUNT-1] = list_reg[AVG_COUNT-1];
        end
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        rfill_next   = rfill_reg;
        held_next    = held_reg;
        idx_next     = idx_reg;
        sum_next     = sum_reg;
        ovalid_next  = ovalid_reg && !out_ready;
        orate_next   = orate_reg;
        opeak_next   = opeak_reg;
        list_wr      = 1'b0;
        cmd_pop      = 1'b0;
        div_start    = 1'b0;
        div_dividend = RATE_NUM;
        div_divisor  = head.interval;
        case (state_reg)
            B_IDLE:
            begin
                if (!queue_empty)
                begin
                    if (head.peak)
                    begin
                        cmd_pop    = 1'b1;
                        div_start  = 1'b1;
                        state_next = B_DIV_RATE;
                    end
                    else if (out_free)
                    begin
                        cmd_pop     = 1'b1;
                        ovalid_next = 1'b1;
                        orate_next  = held_reg;
                        opeak_next  = 1'b0;
                    end
                end
            end
            B_DIV_RATE:
            begin
                if (div_done)
                begin
                    state_next = B_PUSH;
                end
            end
            B_PUSH:
            begin
                list_wr    = 1'b1;
                rfill_next = rlist_full ? rfill_reg : rfill_reg + 1'b1;
                idx_next   = '0;
                sum_next   = '0;
                state_next = (last_after != '0) ? B_SUM : B_OUT;
            end
            B_SUM:
            begin
                sum_next = sum_reg + SUM_W'(list_reg[idx_reg]);
                idx_next = idx_reg + 1'b1;
                if (idx_reg == IDX_LAST)
                begin
                    state_next = B_DIV_AVG;
                end
            end
            B_DIV_AVG:
            begin
                held_next  = mean;
                state_next = B_OUT;
            end
            B_OUT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    orate_next  = held_reg;
                    opeak_next  = 1'b1;
                    state_next  = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // control and rate state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            rfill_reg  <= '0;
            held_reg   <= '0;
            ovalid_reg <= 1'b0;
            for (int k = 0; k < AVG_COUNT; k++)
            begin
                list_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            rfill_reg  <= rfill_next;
            held_reg   <= held_next;
            ovalid_reg <= ovalid_next;
            if (list_wr)
            begin
                for (int k = 0; k < AVG_COUNT; k++)
                begin
                    list_reg[k] <= list_next[k];
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        sum_reg   <= sum_next;
        orate_reg <= orate_next;
        opeak_reg <= opeak_next;
    end

    assign out_valid  = ovalid_reg;
    assign heart_rate = orate_reg;
    assign peak_found = opeak_reg;

endmodule

// File: hw/rtl/pulse_peak_heart_rate_top.sv
// Path: a sample without a counted peak passes the command queue and the result register;
// a counted peak adds the rate division (16 steps), the list push and, when the mean is
// refreshed, a one-entry-a-cycle list sum and the reciprocal mean in state B_DIV_AVG.
// Throughput: the front takes one item a cycle until the command queue is full; the back
// drains one plain item a cycle while m_tready is high, none while a peak item is in work.
// Reset: rst_n clears windows, rate list, held rate and queue; refractory time is 425 ms.
module pulse_peak_heart_rate_top
    import ppr_pkg::*;
#(
    parameter int AVG_COUNT   = AVG_COUNT_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,   // refractory_ms
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,       // sample [15:0], timestamp_ms [47:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,       // heart_rate [7:0]
    output logic        m_tuser        // peak_found [0]
);

    ppr_cmd_t push_cmd;
    ppr_cmd_t head_cmd;
    logic     cmd_push;
    logic     cmd_pop;
    logic     q_full;
    logic     q_empty;

    // front part
    ppr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (s_tvalid),
        .queue_full   (q_full),
        .sample       (s_tdata[15:0]),
        .timestamp_ms (s_tdata[47:16]),
        .in_ready     (s_tready),
        .cmd_push     (cmd_push),
        .cmd          (push_cmd)
    );

    // command queue
    ppr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (push_cmd),
        .pop       (cmd_pop),
        .head      (head_cmd),
        .full      (q_full),
        .empty     (q_empty)
    );

    // back part
    ppr_back #(
        .AVG_COUNT (AVG_COUNT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (q_empty),
        .head        (head_cmd),
        .cmd_pop     (cmd_pop),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .heart_rate  (m_tdata),
        .peak_found  (m_tuser)
    );

endmodule

// File: hw/rtl/ppr_chk.sv
// port-level checker for the pulse peak heart-rate block, with its bind
module ppr_chk
    import ppr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tuser
);

    logic       in_acc;
    logic       out_acc;
    logic [7:0] pending_reg, pending_next;
    logic [7:0] last_hr_reg;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    // items taken whose results are not yet delivered
    always_comb
    begin
        pending_next = pending_reg;
        if (in_acc && !out_acc)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (out_acc && !in_acc)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            last_hr_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            if (out_acc)
            begin
                last_hr_reg <= m_tdata;
            end
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // no result without an item taken earlier
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> pending_reg != 8'd0)
        else $error("result delivered with no item pending");

    // held rate only moves on a counted peak
    a_rate_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && !m_tuser |-> m_tdata == last_hr_reg)
        else $error("heart rate changed without a peak");

endmodule

bind pulse_peak_heart_rate_top ppr_chk u_ppr_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
